// ===== rtl/eftb_pkg.sv =====
// ----------------------------------------------------------------------------
// eftb_pkg
// shared types and constants for the escape filtering text buffer
// ----------------------------------------------------------------------------
package eftb_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_NL,
    ST_FILL
  } ctrl_state_t;

  typedef enum logic [2:0] {
    PS_TEXT    = 3'd0,
    PS_ESC     = 3'd1,
    PS_BRACKET = 3'd2,
    PS_PARAM   = 3'd3,
    PS_INTER   = 3'd4
  } esc_state_t;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [7:0] PARAM_LO = 8'h30;
  localparam logic [7:0] PARAM_HI = 8'h3F;
  localparam logic [7:0] INTER_LO = 8'h20;
  localparam logic [7:0] INTER_HI = 8'h2F;
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7E;

  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET = 7'd50;

endpackage

// ===== rtl/eftb_if.sv =====
// ----------------------------------------------------------------------------
// eftb channel interfaces
// request channel and result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface eftb_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  byte_in;
  logic [11:0] cell_index;

  modport source (output valid, output opcode, output byte_in, output cell_index,
                  input ready);
  modport sink (input valid, input opcode, input byte_in, input cell_index,
                output ready);
endinterface

interface eftb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [12:0] cursor_position;
  logic [2:0]  parser_state;
  logic        sequence_ended;
  logic        text_written;

  modport source (output valid, output read_data, output cursor_position,
                  output parser_state, output sequence_ended, output text_written,
                  input ready);
  modport sink (input valid, input read_data, input cursor_position,
                input parser_state, input sequence_ended, input text_written,
                output ready);
endinterface

// ===== rtl/escape_filter_text_buffer.sv =====
// ----------------------------------------------------------------------------
// escape_filter_text_buffer
// csi escape parser in front of a character store with a linear cursor
// ----------------------------------------------------------------------------
//   channel   | dir | handshake            | contents
//   in_if     | in  | valid/ready          | opcode, byte_in, cell_index
//   out_if    | out | valid/ready          | read_data, cursor, parser state, flags
//   apb       | in  | psel/penable, pready | column_count @0, row_count @4
//
// plain, swallowed and ignored bytes: taken back to back while the output is not stalled
// cell read: the store read is registered, then ST_READ loads the result
// newline: goes through ST_DIV and ST_NL, using the one-bit-per-cycle remainder unit
// form feed: ST_FILL writes a space to every visible cell, one store write per cycle
// after reset a sweep over all CELLS cells zeroes the store; requests wait, config is taken
// a waiting result in the output register holds off requests until it is taken
module escape_filter_text_buffer #(
  parameter int CELLS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  eftb_in_if.sink     in_if,
  eftb_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW = $clog2(CELLS + 1);
  localparam int PW = (CW > 15) ? CW : 15;
  localparam int NW = CW + 9;

  // configuration
  logic [7:0] col_r;
  logic [6:0] row_r;

  // control state
  eftb_pkg::ctrl_state_t state_r, state_nxt;
  eftb_pkg::esc_state_t  esc_r, esc_nxt;
  logic [CW-1:0]         cursor_r, cursor_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         dvd_r, dvd_nxt;
  logic [7:0]            rem_r, rem_nxt;
  logic                  rd_ok_r, rd_ok_nxt;

  // output register
  logic                  ov_r, ov_nxt;
  logic [7:0]            rd_r, rd_nxt;
  logic [12:0]           cur_r, cur_nxt;
  eftb_pkg::esc_state_t  ps_r, ps_nxt;
  logic                  end_r, end_nxt;
  logic                  tw_r, tw_nxt;

  // store
  logic [7:0]    mem [CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_q;

  // parser
  eftb_pkg::esc_state_t p_ns;
  logic                 p_end;
  logic                 p_pass;

  logic [PW-1:0] prod;
  logic [CW-1:0] lim;
  logic [8:0]    rem_sh;
  logic [NW-1:0] nl_next;
  logic          in_ready;
  logic          cfg_wr;

  // visible size
  assign prod = PW'(col_r) * PW'(row_r);
  assign lim  = (prod > PW'(CELLS)) ? CW'(CELLS) : CW'(prod);

  // apb
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? 32'(row_r) : 32'(col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= eftb_pkg::COLS_RESET;
      row_r <= eftb_pkg::ROWS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        row_r <= pwdata[6:0];
      end else begin
        col_r <= pwdata[7:0];
      end
    end
  end

  // csi parser
  always_comb begin
    logic [7:0] c;
    logic       is_param;
    logic       is_inter;
    logic       is_final;
    c        = in_if.byte_in;
    is_param = c inside {[eftb_pkg::PARAM_LO:eftb_pkg::PARAM_HI]};
    is_inter = c inside {[eftb_pkg::INTER_LO:eftb_pkg::INTER_HI]};
    is_final = c inside {[eftb_pkg::FINAL_LO:eftb_pkg::FINAL_HI]};
    p_ns   = eftb_pkg::PS_TEXT;
    p_end  = 1'b0;
    p_pass = 1'b0;
    case (esc_r)
      eftb_pkg::PS_ESC: begin
        if (c == eftb_pkg::CH_BRACKET) begin
          p_ns = eftb_pkg::PS_BRACKET;
        end else begin
          p_pass = 1'b1;
        end
      end
      eftb_pkg::PS_BRACKET, eftb_pkg::PS_PARAM: begin
        if (is_param) begin
          p_ns = eftb_pkg::PS_PARAM;
        end else if (is_inter) begin
          p_ns = eftb_pkg::PS_INTER;
        end else if (is_final) begin
          p_end = 1'b1;
        end else begin
          p_pass = 1'b1;
        end
      end
      eftb_pkg::PS_INTER: begin
        if (is_inter) begin
          p_ns = eftb_pkg::PS_INTER;
        end else if (is_final) begin
          p_end = 1'b1;
        end else begin
          p_pass = 1'b1;
        end
      end
      default: begin
        if (c == eftb_pkg::CH_ESC) begin
          p_ns = eftb_pkg::PS_ESC;
        end else begin
          p_pass = 1'b1;
        end
      end
    endcase
  end

  assign rem_sh  = {rem_r, dvd_r[CW-1]};
  assign nl_next = NW'(cursor_r) - NW'(rem_r) + NW'(col_r);

  // next state and store control
  always_comb begin
    state_nxt  = state_r;
    esc_nxt    = esc_r;
    cursor_nxt = cursor_r;
    cnt_nxt    = cnt_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    rd_ok_nxt  = rd_ok_r;
    ov_nxt     = ov_r && !out_if.ready;
    rd_nxt     = rd_r;
    cur_nxt    = cur_r;
    ps_nxt     = ps_r;
    end_nxt    = end_r;
    tw_nxt     = tw_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    in_ready   = 1'b0;
    case (state_r)
      eftb_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_r);
        if (cnt_r == CW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = eftb_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      eftb_pkg::ST_IDLE: begin
        in_ready = !ov_r || out_if.ready;
        if (in_if.valid && in_ready) begin
          if (in_if.opcode == eftb_pkg::OP_READ) begin
            rd_ok_nxt = 32'(in_if.cell_index) < 32'(CELLS);
            mem_re    = 1'b1;
            mem_raddr = AW'(in_if.cell_index);
            state_nxt = eftb_pkg::ST_READ;
          end else begin
            esc_nxt = p_ns;
            rd_nxt  = '0;
            ps_nxt  = p_ns;
            end_nxt = p_end;
            tw_nxt  = p_pass;
            if (p_pass && in_if.byte_in == eftb_pkg::CH_FF) begin
              cnt_nxt   = '0;
              state_nxt = eftb_pkg::ST_FILL;
            end else if (p_pass && cursor_r < lim &&
                         in_if.byte_in == eftb_pkg::CH_NL) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(cursor_r);
              mem_wdata = eftb_pkg::CH_NL;
              dvd_nxt   = cursor_r;
              rem_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = eftb_pkg::ST_DIV;
            end else begin
              if (p_pass && cursor_r < lim) begin
                if (in_if.byte_in == eftb_pkg::CH_BS) begin
                  if (cursor_r != '0) begin
                    cursor_nxt = cursor_r - 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = AW'(cursor_nxt);
                    mem_wdata  = eftb_pkg::CH_SPACE;
                  end
                end else begin
                  mem_we     = 1'b1;
                  mem_waddr  = AW'(cursor_r);
                  mem_wdata  = in_if.byte_in;
                  cursor_nxt = cursor_r + 1'b1;
                end
              end
              ov_nxt  = 1'b1;
              cur_nxt = 13'(cursor_nxt);
            end
          end
        end
      end
      eftb_pkg::ST_READ: begin
        ov_nxt    = 1'b1;
        rd_nxt    = rd_ok_r ? mem_q : 8'd0;
        cur_nxt   = 13'(cursor_r);
        ps_nxt    = esc_r;
        end_nxt   = 1'b0;
        tw_nxt    = 1'b0;
        state_nxt = eftb_pkg::ST_IDLE;
      end
      eftb_pkg::ST_DIV: begin
        if (rem_sh >= {1'b0, col_r}) begin
          rem_nxt = 8'(rem_sh - {1'b0, col_r});
        end else begin
          rem_nxt = rem_sh[7:0];
        end
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(CW - 1)) begin
          state_nxt = eftb_pkg::ST_NL;
        end
      end
      eftb_pkg::ST_NL: begin
        if (nl_next > NW'(lim)) begin
          cursor_nxt = lim;
        end else begin
          cursor_nxt = CW'(nl_next);
        end
        ov_nxt    = 1'b1;
        cur_nxt   = 13'(cursor_nxt);
        state_nxt = eftb_pkg::ST_IDLE;
      end
      eftb_pkg::ST_FILL: begin
        if (cnt_r < lim) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cnt_r);
          mem_wdata = eftb_pkg::CH_SPACE;
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          cursor_nxt = '0;
          ov_nxt     = 1'b1;
          cur_nxt    = '0;
          state_nxt  = eftb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = eftb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= eftb_pkg::ST_CLEAR;
      esc_r    <= eftb_pkg::PS_TEXT;
      cursor_r <= '0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      esc_r    <= esc_nxt;
      cursor_r <= cursor_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    rd_ok_r <= rd_ok_nxt;
    rd_r    <= rd_nxt;
    cur_r   <= cur_nxt;
    ps_r    <= ps_nxt;
    end_r   <= end_nxt;
    tw_r    <= tw_nxt;
  end

  // character store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  assign in_if.ready            = in_ready;
  assign out_if.valid           = ov_r;
  assign out_if.read_data       = rd_r;
  assign out_if.cursor_position = cur_r;
  assign out_if.parser_state    = ps_r;
  assign out_if.sequence_ended  = end_r;
  assign out_if.text_written    = tw_r;

endmodule

// ===== rtl/eftb_checker.sv =====
// ----------------------------------------------------------------------------
// eftb_checker
// port level checks on the escape filtering text buffer
// ----------------------------------------------------------------------------
module eftb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_data,
  input logic [12:0] out_cursor_position,
  input logic [2:0]  out_parser_state,
  input logic        out_sequence_ended,
  input logic        out_text_written
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_data) && $stable(out_cursor_position)
      && $stable(out_parser_state) && $stable(out_sequence_ended)
      && $stable(out_text_written))
    else $error("result changed while stalled");

  a_back_to_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_sequence_ended || out_text_written) |->
      out_parser_state == eftb_pkg::PS_TEXT && !(out_sequence_ended && out_text_written))
    else $error("parser not back in text state after end or pass-through");

  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during store clear");

endmodule

bind escape_filter_text_buffer eftb_checker u_eftb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_if.ready),
  .out_valid           (out_if.valid),
  .out_ready           (out_if.ready),
  .out_read_data       (out_if.read_data),
  .out_cursor_position (out_if.cursor_position),
  .out_parser_state    (out_if.parser_state),
  .out_sequence_ended  (out_if.sequence_ended),
  .out_text_written    (out_if.text_written)
);

// ===== sim/escape_filter_text_buffer_tb.sv =====
// ----------------------------------------------------------------------------
// escape_filter_text_buffer_tb
// Drives bytes and cell reads into the csi filtering text buffer. Every result
// is checked field by field against an in-bench model of the parser, cursor
// and character store, or against a fixed expected result for some directed
// items. The run starts with a directed walk over the parser states and cursor
// corner cases, then goes through randomized phases, each under a new geometry.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module escape_filter_text_buffer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = 4096;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 10;
  localparam logic [2:0] ADDR_COLUMN_COUNT = 3'd0;
  localparam logic [2:0] ADDR_ROW_COUNT = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  byte_in;
    logic [11:0] cell_index;
  } request_t;

  typedef struct packed {
    logic [7:0]           read_data;
    logic [12:0]          cursor_position;
    eftb_pkg::esc_state_t parser_state;
    logic                 sequence_ended;
    logic                 text_written;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_GEOMETRY} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    request_t   req;
    bit         known;
    result_t    want;
    logic [7:0] cols;
    logic [6:0] rows;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  eftb_in_if  request_bus ();
  eftb_out_if result_bus ();

  escape_filter_text_buffer #(.CELLS(CELLS)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (request_bus),
    .out_if  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // terminal mirror
  logic [7:0]           cols_mirror;
  logic [6:0]           rows_mirror;
  int                   visible_limit;
  int                   cursor_at;
  eftb_pkg::esc_state_t parse_mirror;
  logic [7:0]           screen [CELLS];

  result_t    pending_results [$];
  plan_row_t  plan [$];
  int         mismatches;
  int         items_sent;
  int         burst_left;
  bit         offering;
  int         hold_cycles;
  int         cycle_count;

  int phase_cols [PHASES] = '{128, 1, 1, 128, 7, 0, 127, 13, 80, 0};
  int phase_rows [PHASES] = '{64, 1, 64, 1, 3, 0, 64, 5, 50, 0};
  int phase_items [PHASES] = '{60, 60, 60, 60, 60, 60, 100, 60, 60, 60};
  int phase_nl [PHASES] = '{10, 10, 10, 10, 15, 10, 85, 20, 10, 10};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("escape_filter_text_buffer verification failed");
    $finish;
  end

  function automatic int geometry_size();
    int n;
    n = int'(cols_mirror) * int'(rows_mirror);
    return (n > CELLS) ? CELLS : n;
  endfunction

  function automatic void compare_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d got %0d", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  function automatic result_t advance_terminal(input request_t r);
    result_t              o;
    eftb_pkg::esc_state_t after;
    logic [7:0]           c;
    bit                   is_param;
    bit                   is_inter;
    bit                   is_final;
    bit                   to_store;
    int                   row_start;
    o = '0;
    if (r.opcode == eftb_pkg::OP_READ) begin
      o.read_data = screen[r.cell_index];
    end else begin
      c = r.byte_in;
      is_param = (c >= eftb_pkg::PARAM_LO) && (c <= eftb_pkg::PARAM_HI);
      is_inter = (c >= eftb_pkg::INTER_LO) && (c <= eftb_pkg::INTER_HI);
      is_final = (c >= eftb_pkg::FINAL_LO) && (c <= eftb_pkg::FINAL_HI);
      after = eftb_pkg::PS_TEXT;
      to_store = 1'b0;
      case (parse_mirror)
        eftb_pkg::PS_ESC: begin
          if (c == eftb_pkg::CH_BRACKET) after = eftb_pkg::PS_BRACKET;
          else to_store = 1'b1;
        end
        eftb_pkg::PS_BRACKET, eftb_pkg::PS_PARAM: begin
          if (is_param) after = eftb_pkg::PS_PARAM;
          else if (is_inter) after = eftb_pkg::PS_INTER;
          else if (is_final) o.sequence_ended = 1'b1;
          else to_store = 1'b1;
        end
        eftb_pkg::PS_INTER: begin
          if (is_inter) after = eftb_pkg::PS_INTER;
          else if (is_final) o.sequence_ended = 1'b1;
          else to_store = 1'b1;
        end
        default: begin
          if (c == eftb_pkg::CH_ESC) after = eftb_pkg::PS_ESC;
          else to_store = 1'b1;
        end
      endcase
      if (to_store) begin
        o.text_written = 1'b1;
        if (c == eftb_pkg::CH_FF) begin
          for (int i = 0; i < visible_limit; i++) screen[i] = eftb_pkg::CH_SPACE;
          cursor_at = 0;
        end else if (cursor_at < visible_limit) begin
          if (c == eftb_pkg::CH_NL) begin
            screen[cursor_at] = c;
            row_start = (cursor_at / int'(cols_mirror)) * int'(cols_mirror) + int'(cols_mirror);
            cursor_at = (row_start > visible_limit) ? visible_limit : row_start;
          end else if (c == eftb_pkg::CH_BS) begin
            if (cursor_at != 0) begin
              cursor_at--;
              screen[cursor_at] = eftb_pkg::CH_SPACE;
            end
          end else begin
            screen[cursor_at] = c;
            cursor_at++;
          end
        end
      end
      parse_mirror = after;
    end
    o.cursor_position = 13'(cursor_at);
    o.parser_state = parse_mirror;
    return o;
  endfunction

  // request side: bursts with random gaps, valid held across a burst
  task automatic offer(input request_t r, input bit known = 1'b0, input result_t want = '0);
    int      gap;
    result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        if (offering) request_bus.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    request_bus.valid <= 1'b1;
    request_bus.opcode <= r.opcode;
    request_bus.byte_in <= r.byte_in;
    request_bus.cell_index <= r.cell_index;
    offering = 1'b1;
    do @(posedge clk); while (request_bus.ready !== 1'b1);
    burst_left--;
    items_sent++;
    predicted = advance_terminal(r);
    pending_results.push_back(known ? want : predicted);
  endtask

  task automatic feed_byte(input logic [7:0] b);
    offer(request_t'{eftb_pkg::OP_FEED, b, 12'($urandom_range(0, 4095))});
  endtask

  task automatic read_cell(input logic [11:0] ix);
    offer(request_t'{eftb_pkg::OP_READ, 8'($urandom_range(0, 255)), ix});
  endtask

  task automatic drain();
    if (offering) request_bus.valid <= 1'b0;
    offering = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_transfer(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                              output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
  endtask

  task automatic program_geometry(input logic [7:0] c, input logic [6:0] r);
    logic [31:0] rd;
    apb_transfer(1'b1, ADDR_COLUMN_COUNT, {24'd0, c}, rd);
    cols_mirror = c;
    apb_transfer(1'b1, ADDR_ROW_COUNT, {25'd0, r}, rd);
    rows_mirror = r;
    visible_limit = geometry_size();
    apb_transfer(1'b0, ADDR_COLUMN_COUNT, 32'd0, rd);
    compare_field("column_count", {24'd0, c}, rd);
    apb_transfer(1'b0, ADDR_ROW_COUNT, 32'd0, rd);
    compare_field("row_count", {25'd0, r}, rd);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void plan_item(input logic op, input logic [7:0] b, input logic [11:0] ix,
                                    input bit known = 1'b0, input result_t want = '0);
    plan.push_back('{ROW_ITEM, request_t'{op, b, ix}, known, want, 8'd0, 7'd0});
  endfunction

  // mostly well formed csi and text, broken sequences, noise, reads, form feeds
  task automatic run_traffic(input int n_items, input int nl_pct);
    int         stop_at;
    int         pick;
    int         ff_left;
    int         top;
    logic [7:0] b;
    stop_at = items_sent + n_items;
    ff_left = (visible_limit <= 512) ? 12 : 2;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        repeat ($urandom_range(1, 8)) begin
          pick = $urandom_range(0, 99);
          if (pick < nl_pct) feed_byte(eftb_pkg::CH_NL);
          else if (pick < nl_pct + 8) feed_byte(eftb_pkg::CH_BS);
          else feed_byte(8'($urandom_range('h20, 'h7E)));
        end
      end else if (pick < 65) begin
        feed_byte(eftb_pkg::CH_ESC);
        feed_byte(eftb_pkg::CH_BRACKET);
        repeat ($urandom_range(0, 3))
          feed_byte(8'($urandom_range(eftb_pkg::PARAM_LO, eftb_pkg::PARAM_HI)));
        repeat ($urandom_range(0, 2))
          feed_byte(8'($urandom_range(eftb_pkg::INTER_LO, eftb_pkg::INTER_HI)));
        feed_byte(8'($urandom_range(eftb_pkg::FINAL_LO, eftb_pkg::FINAL_HI)));
      end else if (pick < 73) begin
        feed_byte(eftb_pkg::CH_ESC);
        if ($urandom_range(0, 1) == 0) begin
          b = 8'($urandom_range(0, 255));
          if (b == eftb_pkg::CH_BRACKET) b = eftb_pkg::CH_NL;
          feed_byte(b);
        end else begin
          feed_byte(eftb_pkg::CH_BRACKET);
          repeat ($urandom_range(0, 2))
            feed_byte(8'($urandom_range(eftb_pkg::PARAM_LO, eftb_pkg::PARAM_HI)));
          repeat ($urandom_range(0, 1))
            feed_byte(8'($urandom_range(eftb_pkg::INTER_LO, eftb_pkg::INTER_HI)));
          b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 'h1F))
                                          : 8'($urandom_range('h7F, 'hFF));
          feed_byte(b);
        end
      end else if (pick < 90) begin
        top = (visible_limit + 3 > CELLS - 1) ? CELLS - 1 : visible_limit + 3;
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 3) == 0) read_cell(12'($urandom_range(0, CELLS - 1)));
          else read_cell(12'($urandom_range(0, top)));
        end
      end else if (pick < 98 || ff_left == 0) begin
        feed_byte(8'($urandom_range(0, 255)));
      end else begin
        feed_byte(eftb_pkg::CH_FF);
        ff_left--;
      end
    end
  endtask

  // result side stall pattern, with one long hold-off
  initial begin
    int stall_mode;
    int mode_left;
    int tick;
    mode_left = 0;
    tick = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_cycles > 0) begin
        result_bus.ready <= 1'b0;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (stall_mode)
          0: result_bus.ready <= 1'b1;
          1: result_bus.ready <= ($urandom_range(0, 99) >= 25);
          2: result_bus.ready <= (tick % 3 == 0);
          default: result_bus.ready <= ($urandom_range(0, 99) >= 70);
        endcase
      end
    end
  end

  initial begin
    result_t w;
    forever begin
      @(posedge clk);
      if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with nothing pending, expected none got cursor %0d",
                   $time, result_bus.cursor_position);
          mismatches++;
        end else begin
          w = pending_results.pop_front();
          compare_field("read_data", w.read_data, result_bus.read_data);
          compare_field("cursor_position", w.cursor_position, result_bus.cursor_position);
          compare_field("parser_state", w.parser_state, result_bus.parser_state);
          compare_field("sequence_ended", w.sequence_ended, result_bus.sequence_ended);
          compare_field("text_written", w.text_written, result_bus.text_written);
        end
      end
    end
  end

  initial begin
    result_t   idle_read;
    result_t   stored_first;
    result_t   pass_home;
    plan_row_t row;
    logic [7:0] c;
    logic [6:0] r;

    mismatches = 0;
    items_sent = 0;
    burst_left = 0;
    offering = 1'b0;
    hold_cycles = 0;
    cycle_count = 0;
    cols_mirror = eftb_pkg::COLS_RESET;
    rows_mirror = eftb_pkg::ROWS_RESET;
    visible_limit = geometry_size();
    cursor_at = 0;
    parse_mirror = eftb_pkg::PS_TEXT;
    foreach (screen[i]) screen[i] = 8'h00;

    rst_n <= 1'b0;
    request_bus.valid <= 1'b0;
    request_bus.opcode <= eftb_pkg::OP_FEED;
    request_bus.byte_in <= 8'h00;
    request_bus.cell_index <= 12'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_COLUMN_COUNT;
    pwdata <= 32'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    idle_read = result_t'{8'h00, 13'd0, eftb_pkg::PS_TEXT, 1'b0, 1'b0};
    stored_first = result_t'{8'h00, 13'd1, eftb_pkg::PS_TEXT, 1'b0, 1'b1};
    pass_home = result_t'{8'h00, 13'd0, eftb_pkg::PS_TEXT, 1'b0, 1'b1};
    plan_item(eftb_pkg::OP_READ, 8'h00, 12'd0, 1'b1, idle_read);
    plan_item(eftb_pkg::OP_READ, 8'hFF, 12'hFFF, 1'b1, idle_read);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_BS, 12'hFFF, 1'b1, pass_home);
    plan_item(eftb_pkg::OP_FEED, 8'h41, 12'd0, 1'b1, stored_first);
    plan_item(eftb_pkg::OP_FEED, 8'h00, 12'hABC);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_ESC, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_BRACKET, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::PARAM_LO, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::INTER_HI, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::FINAL_HI, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_ESC, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_BRACKET, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::PARAM_HI, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::FINAL_HI, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_ESC, 12'd0);
    plan_item(eftb_pkg::OP_FEED, 8'h63, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_ESC, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_BRACKET, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::FINAL_LO, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_ESC, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_BRACKET, 12'd0);
    plan_item(eftb_pkg::OP_FEED, 8'hFF, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_NL, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_BS, 12'd0);
    plan.push_back('{ROW_GEOMETRY, '0, 1'b0, '0, 8'd2, 7'd1});
    plan_item(eftb_pkg::OP_FEED, 8'h5A, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_NL, 12'd0);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_FF, 12'd0, 1'b1, pass_home);
    plan_item(eftb_pkg::OP_FEED, 8'h61, 12'd0, 1'b1, stored_first);
    plan_item(eftb_pkg::OP_FEED, eftb_pkg::CH_NL, 12'd0);
    plan_item(eftb_pkg::OP_READ, 8'h00, 12'd1);
    plan_item(eftb_pkg::OP_READ, 8'h00, 12'd3);

    foreach (plan[k]) begin
      row = plan[k];
      if (row.kind == ROW_GEOMETRY) begin
        drain();
        program_geometry(row.cols, row.rows);
      end else begin
        offer(row.req, row.known, row.want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      c = (phase_cols[ph] == 0) ? 8'($urandom_range(1, 128)) : 8'(phase_cols[ph]);
      r = (phase_rows[ph] == 0) ? 7'($urandom_range(1, 64)) : 7'(phase_rows[ph]);
      program_geometry(c, r);
      if (ph == 3) hold_cycles = 400;
      run_traffic(phase_items[ph], phase_nl[ph]);
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("escape_filter_text_buffer verification clean");
    end else begin
      $display("escape_filter_text_buffer verification failed");
    end
    $finish;
  end

endmodule
